FILE: rtl/aavr_pkg.sv
// aavr_pkg: shared constants and the cordic arctangent table for the
// axis-angle vector rotator; no dependencies
`timescale 1ns / 1ps
package aavr_pkg;

   localparam int COORD_WIDTH_DEF  = 24;
   localparam int FRAC_BITS_DEF    = 14;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam int AXIS_WIDTH   = 16;
   localparam int AXIS_FRAC    = 14;
   localparam int CORDIC_FRAC  = 30;
   localparam int ATAN_COUNT   = 30;
   localparam int ANGLE_WIDTH  = 16;
   localparam int REG_COUNT    = 4;

   localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

   // register indexes
   localparam logic [1:0] REG_AXIS_X = 2'd0;
   localparam logic [1:0] REG_AXIS_Y = 2'd1;
   localparam logic [1:0] REG_AXIS_Z = 2'd2;
   localparam logic [1:0] REG_ANGLE  = 2'd3;

   localparam logic [15:0] AXIS_X_RESET = 16'd0;
   localparam logic [15:0] AXIS_Y_RESET = 16'd0;
   localparam logic [15:0] AXIS_Z_RESET = 16'd16384;
   localparam logic [15:0] ANGLE_RESET  = 16'd0;

   // arctangent of 2^-i, 2^32 units per turn
   function automatic logic [31:0] atan_turns(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/axis_angle_vector_rotate.sv
// axis_angle_vector_rotate: top level, register file, and the four-stage
// matrix-times-vector pipeline; uses aavr_pkg and aavr_coef
//
//   channel   | direction | handshake           | payload
//   req_      | in        | req_valid/req_ready | req_vec_x, req_vec_y, req_vec_z
//   rsp_      | out       | rsp_valid/rsp_ready | rsp_rot_x, rsp_rot_y, rsp_rot_z
//   csr_      | in        | psel/penable/pready | paddr, pwdata, prdata
//
// one vector per cycle while the output is not stalled and the matrix is not
// being rebuilt; stages are input reg, nine multipliers, row sums, saturation
// after reset and after any register write, req_ready stays low while the
// matrix is rebuilt
// each stage moves when the one after it is empty or moving, so a stalled
// output only blocks what is queued behind it
`timescale 1ns / 1ps
module axis_angle_vector_rotate #(
   parameter int COORD_WIDTH  = aavr_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS    = aavr_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = aavr_pkg::CORDIC_STEPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COORD_WIDTH-1:0] req_vec_x,
   input  logic [COORD_WIDTH-1:0] req_vec_y,
   input  logic [COORD_WIDTH-1:0] req_vec_z,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COORD_WIDTH-1:0] rsp_rot_x,
   output logic [COORD_WIDTH-1:0] rsp_rot_y,
   output logic [COORD_WIDTH-1:0] rsp_rot_z,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int CW  = COORD_WIDTH;
   localparam int MW  = FRAC_BITS + 7;
   localparam int PW  = MW + CW;
   localparam int SW  = PW + 2;
   localparam int RW  = SW - FRAC_BITS;
   localparam logic signed [SW-1:0] RND  = SW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [RW-1:0] RMAX = (RW'(1) <<< (CW - 1)) - RW'(1);
   localparam logic signed [RW-1:0] RMIN = -(RW'(1) <<< (CW - 1));

   // configuration registers
   logic [15:0] axis_x_ff, axis_y_ff, axis_z_ff, angle_ff;
   logic        wr_en;
   logic        coef_busy;
   logic [8:0][MW-1:0] mtx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_x_ff <= aavr_pkg::AXIS_X_RESET;
         axis_y_ff <= aavr_pkg::AXIS_Y_RESET;
         axis_z_ff <= aavr_pkg::AXIS_Z_RESET;
         angle_ff  <= aavr_pkg::ANGLE_RESET;
      end else if (wr_en) begin
         case (csr_paddr[3:2])
            aavr_pkg::REG_AXIS_X: axis_x_ff <= csr_pwdata[15:0];
            aavr_pkg::REG_AXIS_Y: axis_y_ff <= csr_pwdata[15:0];
            aavr_pkg::REG_AXIS_Z: axis_z_ff <= csr_pwdata[15:0];
            aavr_pkg::REG_ANGLE:  angle_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         aavr_pkg::REG_AXIS_X: csr_prdata = {16'd0, axis_x_ff};
         aavr_pkg::REG_AXIS_Y: csr_prdata = {16'd0, axis_y_ff};
         aavr_pkg::REG_AXIS_Z: csr_prdata = {16'd0, axis_z_ff};
         aavr_pkg::REG_ANGLE:  csr_prdata = {16'd0, angle_ff};
         default:              csr_prdata = '0;
      endcase
   end

   aavr_coef #(
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STEPS (CORDIC_STEPS),
      .MW           (MW)
   ) u_coef (
      .clock      (clock),
      .reset      (reset),
      .start      (wr_en),
      .axis_x     (axis_x_ff),
      .axis_y     (axis_y_ff),
      .axis_z     (axis_z_ff),
      .turn_angle (angle_ff),
      .busy       (coef_busy),
      .mtx        (mtx)
   );

   // pipeline
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;
   logic [CW-1:0]        vec_ff [3];
   logic signed [PW-1:0] prod_ff [9];
   logic signed [PW-1:0] prod_in [9];
   logic signed [RW-1:0] row_ff [3];
   logic signed [RW-1:0] row_in [3];
   logic [CW-1:0]        rot_ff [3];
   logic [CW-1:0]        rot_in [3];

   assign adv4 = !v4_ff || rsp_ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_ready = adv1 && !coef_busy;

   for (genvar r = 0; r < 3; r++) begin : g_row
      logic signed [SW-1:0] acc;
      for (genvar c = 0; c < 3; c++) begin : g_col
         assign prod_in[r*3+c] =
            $signed({{CW{mtx[r*3+c][MW-1]}}, mtx[r*3+c]}) *
            $signed({{MW{vec_ff[c][CW-1]}}, vec_ff[c]});
      end
      assign acc = $signed({{2{prod_ff[r*3][PW-1]}}, prod_ff[r*3]})
                 + $signed({{2{prod_ff[r*3+1][PW-1]}}, prod_ff[r*3+1]})
                 + $signed({{2{prod_ff[r*3+2][PW-1]}}, prod_ff[r*3+2]})
                 + RND;
      assign row_in[r] = RW'(acc >>> FRAC_BITS);
      assign rot_in[r] = (row_ff[r] > RMAX) ? RMAX[CW-1:0] :
                         (row_ff[r] < RMIN) ? RMIN[CW-1:0] : row_ff[r][CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid && req_ready;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         vec_ff[0] <= req_vec_x;
         vec_ff[1] <= req_vec_y;
         vec_ff[2] <= req_vec_z;
      end
      if (adv2) begin
         for (int i = 0; i < 9; i++) prod_ff[i] <= prod_in[i];
      end
      if (adv3) begin
         for (int i = 0; i < 3; i++) row_ff[i] <= row_in[i];
      end
      if (adv4) begin
         for (int i = 0; i < 3; i++) rot_ff[i] <= rot_in[i];
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_rot_x = rot_ff[0];
   assign rsp_rot_y = rot_ff[1];
   assign rsp_rot_z = rot_ff[2];

endmodule

FILE: rtl/aavr_coef.sv
// aavr_coef: builds the 3x3 rotation matrix from axis and angle registers
// with an iterative cordic and a short multiply sequence; uses aavr_pkg
`timescale 1ns / 1ps
module aavr_coef #(
   parameter int FRAC_BITS    = aavr_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = aavr_pkg::CORDIC_STEPS_DEF,
   parameter int MW           = FRAC_BITS + 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [15:0]          axis_x,
   input  logic [15:0]          axis_y,
   input  logic [15:0]          axis_z,
   input  logic [15:0]          turn_angle,
   output logic                 busy,
   output logic [8:0][MW-1:0]   mtx
);

   localparam int NSTEPS = (CORDIC_STEPS < aavr_pkg::ATAN_COUNT) ?
                           CORDIC_STEPS : aavr_pkg::ATAN_COUNT;
   localparam int XW  = 34;
   localparam int ZW  = 33;
   localparam int CW  = FRAC_BITS + 2;    // cos / sin
   localparam int QW  = FRAC_BITS + 3;    // quaternion parts
   localparam int QPW = 2 * QW;
   localparam int PW  = FRAC_BITS + 4;    // rounded products
   localparam int K   = aavr_pkg::CORDIC_FRAC - FRAC_BITS;
   localparam logic signed [XW-1:0] KRND = (K > 0) ? (XW'(1) <<< (K - 1)) : '0;
   localparam logic signed [XW-1:0] ONE  = XW'(1) <<< FRAC_BITS;
   localparam int AQW = aavr_pkg::AXIS_WIDTH + CW;
   localparam logic signed [AQW-1:0] ARND = AQW'(1) <<< (aavr_pkg::AXIS_FRAC - 1);
   localparam logic signed [QPW-1:0] PRND = QPW'(1) <<< (FRAC_BITS - 1);

   localparam logic [2:0] ST_START = 3'd0;
   localparam logic [2:0] ST_ROT   = 3'd1;
   localparam logic [2:0] ST_TRIG  = 3'd2;
   localparam logic [2:0] ST_QUAT  = 3'd3;
   localparam logic [2:0] ST_PROD  = 3'd4;
   localparam logic [2:0] ST_MTX   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [4:0]            step_ff, step_in;
   logic signed [XW-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]  z_ff, z_in;
   logic                  back_ff, back_in;
   logic signed [CW-1:0]  c_ff, s_ff;
   logic signed [QW-1:0]  w_ff, qx_ff, qy_ff, qz_ff;
   // ww xx yy zz xy xz yz wx wy wz
   logic signed [PW-1:0]  p_ff [10];
   logic [8:0][MW-1:0]    mtx_ff;

   logic [31:0]           half_ang;
   logic signed [ZW-1:0]  atan_val;
   logic signed [XW-1:0]  dx, dy, xr, yr, xc, yc;
   logic signed [QW-1:0]  qx_in, qy_in, qz_in;
   logic signed [PW-1:0]  p_in [10];
   logic signed [QW-1:0]  pa [10];
   logic signed [QW-1:0]  pb [10];
   logic signed [MW-1:0]  m_in [9];

   function automatic logic signed [QW-1:0] qmul(input logic [15:0] a,
                                                  input logic signed [CW-1:0] s);
      logic signed [AQW-1:0] p;
      p = $signed({{CW{a[15]}}, a}) * $signed({{aavr_pkg::AXIS_WIDTH{s[CW-1]}}, s});
      p = (p + ARND) >>> aavr_pkg::AXIS_FRAC;
      return p[QW-1:0];
   endfunction

   assign half_ang = {1'b0, turn_angle, 15'd0};
   assign atan_val = $signed({1'b0, aavr_pkg::atan_turns(step_ff)});
   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;
   assign xr = (x_ff + KRND) >>> K;
   assign yr = (y_ff + KRND) >>> K;
   assign xc = (xr > ONE) ? ONE : ((xr < -ONE) ? -ONE : xr);
   assign yc = (yr > ONE) ? ONE : ((yr < -ONE) ? -ONE : yr);

   assign qx_in = qmul(axis_x, s_ff);
   assign qy_in = qmul(axis_y, s_ff);
   assign qz_in = qmul(axis_z, s_ff);

   always_comb begin
      pa[0] = w_ff;  pb[0] = w_ff;
      pa[1] = qx_ff; pb[1] = qx_ff;
      pa[2] = qy_ff; pb[2] = qy_ff;
      pa[3] = qz_ff; pb[3] = qz_ff;
      pa[4] = qx_ff; pb[4] = qy_ff;
      pa[5] = qx_ff; pb[5] = qz_ff;
      pa[6] = qy_ff; pb[6] = qz_ff;
      pa[7] = w_ff;  pb[7] = qx_ff;
      pa[8] = w_ff;  pb[8] = qy_ff;
      pa[9] = w_ff;  pb[9] = qz_ff;
   end

   for (genvar g = 0; g < 10; g++) begin : g_prod
      logic signed [QPW-1:0] full;
      assign full = ($signed({{QW{pa[g][QW-1]}}, pa[g]}) *
                     $signed({{QW{pb[g][QW-1]}}, pb[g]}) + PRND) >>> FRAC_BITS;
      assign p_in[g] = full[PW-1:0];
   end

   function automatic logic signed [MW-1:0] ext(input logic signed [PW-1:0] v);
      return $signed({{(MW - PW){v[PW-1]}}, v});
   endfunction

   always_comb begin
      m_in[0] = ext(p_ff[0]) + ext(p_ff[1]) - ext(p_ff[2]) - ext(p_ff[3]);
      m_in[1] = (ext(p_ff[4]) - ext(p_ff[9])) <<< 1;
      m_in[2] = (ext(p_ff[5]) + ext(p_ff[8])) <<< 1;
      m_in[3] = (ext(p_ff[4]) + ext(p_ff[9])) <<< 1;
      m_in[4] = ext(p_ff[0]) - ext(p_ff[1]) + ext(p_ff[2]) - ext(p_ff[3]);
      m_in[5] = (ext(p_ff[6]) - ext(p_ff[7])) <<< 1;
      m_in[6] = (ext(p_ff[5]) - ext(p_ff[8])) <<< 1;
      m_in[7] = (ext(p_ff[6]) + ext(p_ff[7])) <<< 1;
      m_in[8] = ext(p_ff[0]) - ext(p_ff[1]) - ext(p_ff[2]) + ext(p_ff[3]);
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      back_in  = back_ff;
      case (state_ff)
         ST_START: begin
            back_in  = half_ang > 32'h4000_0000;
            z_in     = back_in ? $signed(ZW'(32'h8000_0000 - half_ang))
                               : $signed(ZW'(half_ang));
            x_in     = $signed({2'b00, aavr_pkg::CORDIC_GAIN});
            y_in     = '0;
            step_in  = '0;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            if (!z_ff[ZW-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_val;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_val;
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(NSTEPS - 1)) state_in = ST_TRIG;
         end
         ST_TRIG: state_in = ST_QUAT;
         ST_QUAT: state_in = ST_PROD;
         ST_PROD: state_in = ST_MTX;
         ST_MTX:  state_in = ST_DONE;
         ST_DONE: state_in = ST_DONE;
         default: state_in = ST_START;
      endcase
      if (start) state_in = ST_START;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      back_ff <= back_in;
      if (state_ff == ST_TRIG) begin
         c_ff <= xc[CW-1:0];
         s_ff <= yc[CW-1:0];
      end
      if (state_ff == ST_QUAT) begin
         w_ff  <= back_ff ? -$signed({c_ff[CW-1], c_ff}) : $signed({c_ff[CW-1], c_ff});
         qx_ff <= qx_in;
         qy_ff <= qy_in;
         qz_ff <= qz_in;
      end
      if (state_ff == ST_PROD) begin
         for (int i = 0; i < 10; i++) p_ff[i] <= p_in[i];
      end
      if (state_ff == ST_MTX) begin
         for (int i = 0; i < 9; i++) mtx_ff[i] <= m_in[i];
      end
   end

   assign busy = state_ff != ST_DONE;
   assign mtx  = mtx_ff;

endmodule

FILE: rtl/aavr_checker.sv
// aavr_checker: port-level assertions for axis_angle_vector_rotate, bound
// onto the top level; no package dependency
`timescale 1ns / 1ps
module aavr_checker #(
   parameter int COORD_WIDTH = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [COORD_WIDTH-1:0] rsp_rot_x,
   input logic                   csr_psel,
   input logic                   csr_penable,
   input logic                   csr_pwrite,
   input logic                   csr_pready
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result transaction shown right after reset");

   // a register write rebuilds the matrix, so no input is taken next cycle
   a_write_blocks: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite) |=> !req_ready)
      else $error("input taken while matrix is being rebuilt");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr port not ready");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_rot_x)))
      else $error("stalled result transaction changed");

endmodule

bind axis_angle_vector_rotate aavr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_aavr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_rot_x   (rsp_rot_x),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_pready  (csr_pready)
);
